// ===== rtl/gcl_pkg.sv =====
// Shared constants, types and helpers for the grid cell locator.
// No dependencies; imported by every module of the block.
package gcl_pkg;

   localparam int MAX_CELLS = 256;
   localparam int IDX_W     = $clog2(MAX_CELLS);
   localparam int CNT_W     = 9;
   localparam int COORD_W   = 32;
   localparam int ENTRY_W   = 8;
   localparam int CELL_W    = 8;
   localparam int OP_W      = 2;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_X = 2'd0,
      OP_LOAD_Y = 2'd1,
      OP_LOCATE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_X_COUNT = 1'b0,
      CSR_Y_COUNT = 1'b1
   } csr_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] idx;
   } lane_rsp_type;

   // Upper midpoint of [lo, hi]; the span needs one extra bit.
   function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
      logic [IDX_W:0] span;
      span = {1'b0, hi} - {1'b0, lo} + {{IDX_W{1'b0}}, 1'b1};
      return lo + IDX_W'(span >> 1);
   endfunction

endpackage

// ===== rtl/gcl_lane.sv =====
// One search lane: a start table in a memory and an iterative binary search.
// Depends on gcl_pkg.
module gcl_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [gcl_pkg::IDX_W-1:0]   wr_addr,
   input  logic signed [gcl_pkg::COORD_W-1:0] wr_data,
   input  logic                        start,
   input  logic signed [gcl_pkg::COORD_W-1:0] key,
   input  logic [gcl_pkg::CNT_W-1:0]   count,
   output gcl_pkg::lane_rsp_type       rsp
);
   import gcl_pkg::*;

   typedef enum logic {
      IDLE,
      SEARCH
   } state_type;

   state_type                 state_ff;
   logic signed [COORD_W-1:0] mem [MAX_CELLS];
   logic signed [COORD_W-1:0] rd_data_ff;
   logic signed [COORD_W-1:0] key_ff;
   logic [IDX_W-1:0]          lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0]          lo_in, hi_in, rd_addr, hi_start, idx_ff;
   logic [CNT_W-1:0]          n_clamp;
   logic                      done_ff, cmp_ge;

   always_comb begin
      n_clamp  = (count > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : count;
      hi_start = IDX_W'(n_clamp - {{(CNT_W-1){1'b0}}, 1'b1});
      cmp_ge   = key_ff >= rd_data_ff;
      lo_in    = cmp_ge ? mid_ff : lo_ff;
      hi_in    = cmp_ge ? hi_ff : mid_ff - {{(IDX_W-1){1'b0}}, 1'b1};
      if (state_ff == IDLE) begin
         rd_addr = mid_of({IDX_W{1'b0}}, hi_start);
      end else begin
         rd_addr = mid_of(lo_in, hi_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start) begin
                  if (n_clamp < CNT_W'(2)) begin
                     done_ff <= 1'b1;
                     idx_ff  <= '0;
                  end else begin
                     lo_ff    <= '0;
                     hi_ff    <= hi_start;
                     mid_ff   <= rd_addr;
                     key_ff   <= key;
                     state_ff <= SEARCH;
                  end
               end
            end
            SEARCH: begin
               // Narrow the interval; stop once it holds one index.
               if (lo_in >= hi_in) begin
                  done_ff  <= 1'b1;
                  idx_ff   <= lo_in;
                  state_ff <= IDLE;
               end else begin
                  lo_ff  <= lo_in;
                  hi_ff  <= hi_in;
                  mid_ff <= rd_addr;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.idx  = idx_ff;

`ifndef SYNTHESIS
   a_interval_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEARCH |-> lo_ff < hi_ff)
      else $error("search interval collapsed while searching");
   a_done_cause: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(start || state_ff == SEARCH))
      else $error("lane finished without a search");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == IDLE)
      else $error("lane started while busy");
`endif

endmodule

// ===== rtl/gcl_merge.sv =====
// Merge stage: gathers column and row answers and drives the result register.
// Depends on gcl_pkg.
module gcl_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  gcl_pkg::lane_rsp_type           col_rsp,
   input  gcl_pkg::lane_rsp_type           row_rsp,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [gcl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            load_done
);
   import gcl_pkg::*;

   logic                  col_got_ff, row_got_ff, col_got_in, row_got_in;
   logic [IDX_W-1:0]      col_idx_ff, row_idx_ff;
   logic                  out_valid_ff, out_valid_in, load;
   logic [RSP_DATA_W-1:0] out_data_ff;

   always_comb begin
      load         = col_got_ff && row_got_ff && (!out_valid_ff || rsp_tready);
      col_got_in   = !load && (col_got_ff || col_rsp.done);
      row_got_in   = !load && (row_got_ff || row_rsp.done);
      out_valid_in = load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_got_ff   <= 1'b0;
         row_got_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_got_ff   <= col_got_in;
         row_got_ff   <= row_got_in;
         out_valid_ff <= out_valid_in;
      end
      if (col_rsp.done) begin
         col_idx_ff <= col_rsp.idx;
      end
      if (row_rsp.done) begin
         row_idx_ff <= row_rsp.idx;
      end
      if (load) begin
         out_data_ff <= {CELL_W'(row_idx_ff), CELL_W'(col_idx_ff)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign load_done  = load;

`ifndef SYNTHESIS
   a_load_both: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(col_got_ff && row_got_ff))
      else $error("result loaded before both lanes answered");
`endif

endmodule

// ===== rtl/grid_cell_locator_top.sv =====
// Grid cell locator: column and row start tables with binary search per axis.
// Depends on gcl_pkg, gcl_lane and gcl_merge.
//
// Usage:
//  - req_* carries one item per transfer. req_tuser is the opcode: load x
//    entry, load y entry or locate. req_tdata holds the entry index, the
//    load value and the query point.
//  - A load writes one table entry in the cycle it is accepted and gives no
//    result; the next item may follow at once.
//  - A locate searches the x and y tables in two lanes side by side, one
//    memory probe per cycle per lane, and gives one result on rsp_* with
//    the column in the low byte and the row in the high byte.
//  - Locate time is set by the probe loop on each lane's table memory and
//    grows with the larger clamped axis count; counts 0 or 1 need no probe.
//    No new item is accepted while a locate is in flight; req_tready
//    returns as the result register loads.
//  - A stalled receiver holds the result in the output register; one more
//    locate may finish its search and then waits in the merge stage.
//  - Reset clears the control state and sets both counts to 1; the tables
//    are undefined until loaded. csr_* writes the counts; the user must
//    do so only while idle, as the block itself does not enforce it.
module grid_cell_locator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] entry_index, [39:8] load_value, [71:40] query_x, [103:72] query_y
   input  logic [gcl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] opcode
   input  logic [gcl_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] cell_col, [15:8] cell_row
   output logic [gcl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [gcl_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gcl_pkg::CNT_W-1:0]       csr_wdata
);
   import gcl_pkg::*;

   logic [CNT_W-1:0]          x_count_ff, y_count_ff;
   logic                      busy_ff, busy_in;
   logic                      accept, locate, load_ok, load_done;
   op_type                    op;
   logic [ENTRY_W-1:0]        entry_index;
   logic signed [COORD_W-1:0] load_value, query_x, query_y;
   lane_rsp_type              col_rsp, row_rsp;

   // Unpack the request fields.
   assign op          = op_type'(req_tuser);
   assign entry_index = req_tdata[ENTRY_W-1:0];
   assign load_value  = req_tdata[ENTRY_W +: COORD_W];
   assign query_x     = req_tdata[ENTRY_W+COORD_W +: COORD_W];
   assign query_y     = req_tdata[ENTRY_W+2*COORD_W +: COORD_W];

   // Hold off new items from a locate transfer until its result is loaded.
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign locate     = accept && (op == OP_LOCATE);
   // Drop loads whose index lies outside the tables.
   assign load_ok    = accept && (32'(entry_index) < MAX_CELLS);
   assign busy_in    = locate || (busy_ff && !load_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         x_count_ff <= CNT_W'(1);
         y_count_ff <= CNT_W'(1);
      end else begin
         busy_ff <= busy_in;
         if (csr_we) begin
            case (csr_type'(csr_addr))
               CSR_X_COUNT: x_count_ff <= csr_wdata;
               CSR_Y_COUNT: y_count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   gcl_lane u_col_lane (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_ok && (op == OP_LOAD_X)),
      .wr_addr (IDX_W'(entry_index)),
      .wr_data (load_value),
      .start   (locate),
      .key     (query_x),
      .count   (x_count_ff),
      .rsp     (col_rsp)
   );

   gcl_lane u_row_lane (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_ok && (op == OP_LOAD_Y)),
      .wr_addr (IDX_W'(entry_index)),
      .wr_data (load_value),
      .start   (locate),
      .key     (query_y),
      .count   (y_count_ff),
      .rsp     (row_rsp)
   );

   gcl_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .col_rsp    (col_rsp),
      .row_rsp    (row_rsp),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .load_done  (load_done)
   );

endmodule

// ===== verif/tb_grid_cell_locator_top.sv =====
// Self-checking testbench for grid_cell_locator_top: loads column and row start tables,
// sweeps the axis counts and checks every located cell against a local binary search.
// Depends on gcl_pkg and the grid_cell_locator_top RTL.
`timescale 1ns / 100ps

module tb_grid_cell_locator_top;
   import gcl_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 16;    // worst locate latency plus margin
   localparam int ITEM_TARGET   = 1300;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [CELL_W-1:0] row;
      logic [CELL_W-1:0] col;
   } cell_pair_type;

   // Mirror of both start tables and counts; queues the cell each locate must yield.
   class cell_lookup_board;
      logic signed [COORD_W-1:0] col_starts [MAX_CELLS];
      logic signed [COORD_W-1:0] row_starts [MAX_CELLS];
      bit                        col_loaded [MAX_CELLS];
      bit                        row_loaded [MAX_CELLS];
      logic [CNT_W-1:0]          x_count = 1;
      logic [CNT_W-1:0]          y_count = 1;
      cell_pair_type             cells_due [$];
      int                        errors;

      // Greatest index whose start is at or below key, over the clamped count.
      function logic [CELL_W-1:0] find_cell(bit on_rows, logic signed [COORD_W-1:0] key);
         int n, lo, hi, mid;
         logic signed [COORD_W-1:0] probe;
         n = on_rows ? int'(y_count) : int'(x_count);
         if (n > MAX_CELLS) n = MAX_CELLS;
         if (n < 2) return '0;
         lo = 0;
         hi = n - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            probe = on_rows ? row_starts[mid] : col_starts[mid];
            if (key >= probe) lo = mid;
            else hi = mid - 1;
         end
         return CELL_W'(lo);
      endfunction

      function void set_count(csr_type sel, logic [CNT_W-1:0] value);
         case (sel)
            CSR_X_COUNT: x_count = value;
            CSR_Y_COUNT: y_count = value;
            default: ;
         endcase
      endfunction

      function void take_request(op_type op, logic [ENTRY_W-1:0] idx,
                                 logic signed [COORD_W-1:0] value,
                                 logic signed [COORD_W-1:0] qx,
                                 logic signed [COORD_W-1:0] qy);
         cell_pair_type due;
         case (op)
            OP_LOAD_X: begin
               col_starts[idx] = value;
               col_loaded[idx] = 1'b1;
            end
            OP_LOAD_Y: begin
               row_starts[idx] = value;
               row_loaded[idx] = 1'b1;
            end
            OP_LOCATE: begin
               due.col = find_cell(1'b0, qx);
               due.row = find_cell(1'b1, qy);
               cells_due = {cells_due, due};
            end
            default: ;
         endcase
      endfunction

      function void check_cell(logic [RSP_DATA_W-1:0] data);
         cell_pair_type want;
         if (cells_due.size() == 0) begin
            $display("%0t: cell col %0d row %0d arrived with none pending",
                     $time, data[7:0], data[15:8]);
            errors++;
            return;
         end
         want = cells_due.pop_front();
         if (data[7:0] != want.col) begin
            $display("%0t: cell_col expected %0d actual %0d", $time, want.col, data[7:0]);
            errors++;
         end
         if (data[15:8] != want.row) begin
            $display("%0t: cell_row expected %0d actual %0d", $time, want.row, data[15:8]);
            errors++;
         end
      endfunction

      function int pending();
         return cells_due.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = OP_NONE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = CSR_X_COUNT;
   logic [CNT_W-1:0]        csr_wdata  = '0;

   cell_lookup_board board = new();
   int  items_sent;
   int  cycles;
   bit  steady;        // sender offers back to back while set
   int  hold_req;      // long receiver hold-offs asked for so far

   grid_cell_locator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: give up on a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_cell_locator_top verification failed");
         $finish;
      end
   end

   // Sample every transfer at the edge that completes it; register writes feed
   // the mirror counts, requests feed the predictor, results are checked in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.set_count(csr_type'(csr_addr), csr_wdata);
         if (req_tvalid && req_tready)
            board.take_request(op_type'(req_tuser), req_tdata[7:0], req_tdata[39:8],
                               req_tdata[71:40], req_tdata[103:72]);
         if (rsp_tvalid && rsp_tready) board.check_cell(rsp_tdata);
      end
   end

   // Receiver: ready runs of random length, mostly short stalls, a few long ones,
   // and one long hold-off on request so the block backs up into its input.
   initial begin
      int run, stall, r, holds_done;
      holds_done = 0;
      @(posedge clock);
      forever begin
         if (hold_req > holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            run = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 12);
            rsp_tready <= 1'b1;
            repeat (run) @(posedge clock);
            r = $urandom_range(0, 99);
            stall = (r < 40) ? 0 :
                    (r < 85) ? $urandom_range(1, 3) :
                    (r < 96) ? $urandom_range(4, 10) : $urandom_range(20, 60);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item and hold it until the transfer completes. Valid is only
   // dropped when a gap follows, so it never gets two updates in one step.
   task automatic send_item(op_type op, logic [ENTRY_W-1:0] idx, logic [COORD_W-1:0] value,
                            logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {qy, qx, value, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stop offering, wait for every pending cell, then let any load settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_counts(logic [CNT_W-1:0] nx, logic [CNT_W-1:0] ny);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_X_COUNT;
      csr_wdata <= nx;
      @(posedge clock);
      csr_addr  <= CSR_Y_COUNT;
      csr_wdata <= ny;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Query coordinate: extremes, random points, and hits on or next to a start.
   function automatic logic [COORD_W-1:0] pick_coord(bit on_rows);
      int n, k, r;
      logic [COORD_W-1:0] start;
      n = on_rows ? int'(board.y_count) : int'(board.x_count);
      if (n > MAX_CELLS) n = MAX_CELLS;
      r = $urandom_range(0, 99);
      if (r < 8) return COORD_MIN;
      if (r < 16) return COORD_MAX;
      if (r < 35 || n == 0) return $urandom;
      k = $urandom_range(0, n - 1);
      if (on_rows ? !board.row_loaded[k] : !board.col_loaded[k]) return $urandom;
      start = on_rows ? board.row_starts[k] : board.col_starts[k];
      case ($urandom_range(0, 2))
         0: return start;
         1: return start - 1;
         default: return start + 1;
      endcase
   endfunction

   // Fill one axis with ascending starts: spread over the whole range, spread and
   // pinned to both extremes, or clustered with repeats. Large tables only fill
   // entries not loaded yet, so stale entries may leave them out of order.
   task automatic load_axis(op_type op, logic [CNT_W-1:0] cnt);
      int     n, mode;
      bit     fresh, loaded;
      longint span, value;
      n = (cnt > MAX_CELLS) ? MAX_CELLS : int'(cnt);
      fresh = (n <= 40);
      mode = $urandom_range(0, 2);
      span = 64'sd4294967296 / ((n == 0) ? 1 : n);
      value = longint'($signed($urandom));
      if (value > 64'sd2147482000) value = value - 64'sd4096;
      for (int i = 0; i < n; i++) begin
         if (mode == 2) begin
            value = value + $urandom_range(0, 3);
         end else begin
            value = -64'sd2147483648 + longint'(i) * span + $urandom_range(0, span - 1);
            if (mode == 1 && i == 0) value = -64'sd2147483648;
            if (mode == 1 && i == n - 1) value = 64'sd2147483647;
         end
         loaded = (op == OP_LOAD_X) ? board.col_loaded[i] : board.row_loaded[i];
         if (fresh || !loaded) send_item(op, ENTRY_W'(i), value[31:0], $urandom, $urandom);
      end
   endtask

   function automatic logic [CNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return CNT_W'($urandom_range(0, 1));
      if (r < 65) return CNT_W'($urandom_range(2, 12));
      if (r < 80) return CNT_W'($urandom_range(13, 64));
      if (r < 93) return CNT_W'(MAX_CELLS);
      return CNT_W'($urandom_range(MAX_CELLS + 1, 511));
   endfunction

   initial begin
      int phase, n_ops, r;
      logic [CNT_W-1:0] nx, ny;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Counts of one after reset: every locate lands in cell 0, no table read.
      send_item(OP_LOCATE, 8'h00, COORD_MAX, COORD_MIN, COORD_MIN);
      send_item(OP_LOCATE, 8'hFF, COORD_MIN, COORD_MAX, COORD_MAX);
      send_item(OP_LOCATE, 8'h5A, 32'h0, 32'h0, 32'hFFFF_FFFF);
      // Unknown opcode: dropped without a result.
      send_item(OP_NONE, 8'hFF, $urandom, $urandom, $urandom);

      // Empty grid.
      drain();
      set_counts(9'd0, 9'd0);
      send_item(OP_LOCATE, 8'h00, 32'h0, COORD_MAX, COORD_MIN);

      // Two-entry grid, x starts at the extremes; also touch the top entry index.
      drain();
      set_counts(9'd2, 9'd2);
      send_item(OP_LOAD_X, 8'd0, COORD_MIN, 32'h0, 32'h0);
      send_item(OP_LOAD_X, 8'd1, COORD_MAX, 32'h0, 32'h0);
      send_item(OP_LOAD_Y, 8'd0, COORD_MIN, 32'h0, 32'h0);
      send_item(OP_LOAD_Y, 8'd1, 32'h0, 32'h0, 32'h0);
      send_item(OP_LOAD_X, 8'd255, 32'h5555_5555, 32'h0, 32'h0);
      send_item(OP_LOAD_Y, 8'd255, 32'hAAAA_AAAA, 32'h0, 32'h0);
      send_item(OP_LOCATE, 8'd0, 32'h0, COORD_MAX, 32'hFFFF_FFFF);
      send_item(OP_LOCATE, 8'd0, 32'h0, COORD_MAX - 1, 32'h0);
      send_item(OP_LOCATE, 8'd0, 32'h0, COORD_MIN, COORD_MAX);
      send_item(OP_LOCATE, 8'd0, 32'h0, COORD_MIN, COORD_MIN);

      // Random phases: new counts while idle, fresh tables, then mostly locates.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         nx = pick_count();
         ny = pick_count();
         if (phase == 3) begin
            nx = CNT_W'(MAX_CELLS);
            ny = CNT_W'(MAX_CELLS);
         end
         if (phase == 5) begin
            nx = 9'd511;
            ny = CNT_W'(MAX_CELLS + 1);
         end
         drain();
         set_counts(nx, ny);
         steady = (phase == 3) || ($urandom_range(0, 4) == 0);
         load_axis(OP_LOAD_X, nx);
         load_axis(OP_LOAD_Y, ny);
         // Phase 3 holds off the receiver while locates keep coming, filling the block.
         if (phase == 3) hold_req++;
         n_ops = (phase == 3) ? 60 : $urandom_range(20, 60);
         for (int j = 0; j < n_ops; j++) begin
            r = $urandom_range(0, 99);
            if (r < 78)
               send_item(OP_LOCATE, ENTRY_W'($urandom), $urandom,
                         pick_coord(1'b0), pick_coord(1'b1));
            else if (r < 90)
               send_item((r < 84) ? OP_LOAD_X : OP_LOAD_Y, ENTRY_W'($urandom), $urandom,
                         $urandom, $urandom);
            else
               send_item(OP_NONE, ENTRY_W'($urandom), $urandom, $urandom, $urandom);
         end
         steady = 1'b0;
         phase++;
      end

      drain();
      if (board.errors == 0) begin
         $display("grid_cell_locator_top verification clean");
      end else begin
         $display("grid_cell_locator_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gcl_pkg.sv
rtl/gcl_lane.sv
rtl/gcl_merge.sv
rtl/grid_cell_locator_top.sv
verif/tb_grid_cell_locator_top.sv
